// ----- rtl/core/hex_checksum_frame_encoder_defines.svh -----
// Assertion macros shared by the frame encoder checker.
`ifndef HEX_CHECKSUM_FRAME_ENCODER_DEFINES_SVH
`define HEX_CHECKSUM_FRAME_ENCODER_DEFINES_SVH

// Clocked property, masked while reset is asserted.
`define HCFE_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked at every edge including reset.
`define HCFE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/hcfe_pkg.sv -----
// Types, constants and helpers shared by the frame encoder modules.
package hcfe_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_END   = CFG_IDX_W'(1);

    localparam logic [BYTE_W-1:0] START_RESET = 8'h02;
    localparam logic [BYTE_W-1:0] END_RESET   = 8'h03;

    localparam logic [BYTE_W-1:0] HEX_ZERO  = 8'h30;          // '0'
    localparam logic [BYTE_W-1:0] HEX_ALPHA = 8'h41 - 8'd10;  // 'A' - 10

    // One classified payload beat, as queued between front and back.
    typedef struct packed {
        logic [BYTE_W-1:0] payload;
        logic              first;   // opens a frame: start byte goes ahead of it
        logic              last;    // closes a frame: checksum tail follows
        logic [BYTE_W-1:0] sum;     // running sum including this byte
        logic [BYTE_W-1:0] xr;      // running xor including this byte
    } t_entry;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_DATA,
        PH_SUM_HI,
        PH_SUM_LO,
        PH_XOR_HI,
        PH_XOR_LO,
        PH_END
    } t_phase;

    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
        logic [BYTE_W-1:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10) begin
            return wide + HEX_ZERO;
        end
        return wide + HEX_ALPHA;
    endfunction

endpackage

// ----- rtl/core/hcfe_fifo.sv -----
// Short entry queue between the classifying front and the emitting back.
module hcfe_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hcfe_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output hcfe_pkg::t_entry o_head,
    output logic            o_empty
);
    import hcfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry            r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/hcfe_front.sv -----
// Input side: frame tracking and running sum/xor, one beat per cycle until queue full.
module hcfe_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hcfe_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_last,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output hcfe_pkg::t_entry            o_q_data
);
    import hcfe_pkg::*;

    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic              r_in_frame, n_in_frame;
    logic [BYTE_W-1:0] acc_sum, acc_xor;
    logic              accept;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign o_q_push = accept;
    assign acc_sum  = r_sum + i_byte;
    assign acc_xor  = r_xor ^ i_byte;

    always_comb begin
        o_q_data.payload = i_byte;
        o_q_data.first   = !r_in_frame;
        o_q_data.last    = i_last;
        o_q_data.sum     = acc_sum;
        o_q_data.xr      = acc_xor;

        n_sum      = r_sum;
        n_xor      = r_xor;
        n_in_frame = r_in_frame;
        if (accept) begin
            if (i_last) begin
                n_sum      = '0;
                n_xor      = '0;
                n_in_frame = 1'b0;
            end else begin
                n_sum      = acc_sum;
                n_xor      = acc_xor;
                n_in_frame = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_xor      <= '0;
            r_in_frame <= 1'b0;
        end else begin
            r_sum      <= n_sum;
            r_xor      <= n_xor;
            r_in_frame <= n_in_frame;
        end
    end

endmodule

// ----- rtl/core/hcfe_back.sv -----
// Output side: expands queued entries into framed bytes through an output register.
module hcfe_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hcfe_pkg::t_entry            i_head,
    input  logic                        i_q_empty,
    output logic                        o_q_pop,
    input  logic [hcfe_pkg::BYTE_W-1:0] i_start_byte,
    input  logic [hcfe_pkg::BYTE_W-1:0] i_end_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hcfe_pkg::BYTE_W-1:0] o_byte,
    output logic                        o_last
);
    import hcfe_pkg::*;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_last;
    logic              emit_pop;
    logic              out_load, fire;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    assign out_load = !r_out_valid || i_ready;
    assign fire     = !i_q_empty && out_load;
    assign o_q_pop  = fire && emit_pop;
    assign o_valid  = r_out_valid;
    assign o_byte   = r_out_byte;
    assign o_last   = r_out_last;

    always_comb begin
        n_phase   = r_phase;
        emit_byte = i_head.payload;
        emit_last = 1'b0;
        emit_pop  = 1'b0;
        unique case (r_phase)
            PH_HEAD: begin
                if (i_head.first) begin
                    emit_byte = i_start_byte;
                    n_phase   = PH_DATA;
                end else begin
                    emit_last = !i_head.last;
                    emit_pop  = !i_head.last;
                    n_phase   = i_head.last ? PH_SUM_HI : PH_HEAD;
                end
            end
            PH_DATA: begin
                emit_last = !i_head.last;
                emit_pop  = !i_head.last;
                n_phase   = i_head.last ? PH_SUM_HI : PH_HEAD;
            end
            PH_SUM_HI: begin
                emit_byte = hex_digit(i_head.sum[7:4]);
                n_phase   = PH_SUM_LO;
            end
            PH_SUM_LO: begin
                emit_byte = hex_digit(i_head.sum[3:0]);
                n_phase   = PH_XOR_HI;
            end
            PH_XOR_HI: begin
                emit_byte = hex_digit(i_head.xr[7:4]);
                n_phase   = PH_XOR_LO;
            end
            PH_XOR_LO: begin
                emit_byte = hex_digit(i_head.xr[3:0]);
                n_phase   = PH_END;
            end
            PH_END: begin
                emit_byte = i_end_byte;
                emit_last = 1'b1;
                emit_pop  = 1'b1;
                n_phase   = PH_HEAD;
            end
            default: begin
                n_phase = PH_HEAD;
            end
        endcase
        if (!fire) begin
            n_phase = r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEAD;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (out_load) begin
                r_out_valid <= !i_q_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_byte <= emit_byte;
            r_out_last <= emit_last;
        end
    end

endmodule

// ----- rtl/core/hex_checksum_frame_encoder.sv -----
// Top level of the STX/ETX frame encoder with ASCII hex sum-8 and xor-8 tail.
//
// Input stream (i_s_*): one payload character per beat, tlast on the final
// character of a frame. Output stream (o_m_*): the framed bytes, that is the
// start byte, each payload byte, sum high/low hex digits, xor high/low hex
// digits and the end byte. o_m_tlast marks the final output beat caused by
// one input beat: every mid-frame payload byte, and the end byte of a frame.
// Config channel (i_cfg_*): index 0 sets the start byte, index 1 the end
// byte; other indexes are dropped. Always ready; write only while idle.
// An accepted beat goes through a queue entry, then the output register.
// Throughput: one output beat per cycle from the back sequencer while
// the receiver is ready; each input beat yields its payload byte, after
// the start byte when it opens a frame and before the hex digits and end
// byte when it closes one. The front takes one beat per cycle while the
// queue has room, so short stalls of the back side are absorbed.
// Reset clears both accumulators, closes any open frame, empties the queue
// and the output register, and restores start 0x02 / end 0x03.
// When the receiver deasserts i_m_tready the output beat holds, the queue
// fills, and then o_s_tready drops until the back side moves again.
module hex_checksum_frame_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [hcfe_pkg::BYTE_W-1:0]    i_s_tdata,   // [7:0] payload_byte
    input  logic                           i_s_tlast,   // last_in_frame
    // master stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [hcfe_pkg::BYTE_W-1:0]    o_m_tdata,   // [7:0] out_byte
    output logic                           o_m_tlast,   // run_last
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hcfe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hcfe_pkg::BYTE_W-1:0]    i_cfg_data
);
    import hcfe_pkg::*;

    logic [BYTE_W-1:0] r_start_byte;
    logic [BYTE_W-1:0] r_end_byte;
    logic              q_full, q_empty, q_push, q_pop;
    t_entry            q_in, q_head;

    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_RESET;
            r_end_byte   <= END_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_START: r_start_byte <= i_cfg_data;
                CFG_IDX_END:   r_end_byte   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    hcfe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_in)
    );

    hcfe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    hcfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_start_byte (r_start_byte),
        .i_end_byte   (r_end_byte),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_byte       (o_m_tdata),
        .o_last       (o_m_tlast)
    );

endmodule

// ----- rtl/core/hcfe_checker.sv -----
// Port-level checker for the frame encoder, bound to the top level.
`include "hex_checksum_frame_encoder_defines.svh"

module hcfe_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [hcfe_pkg::BYTE_W-1:0]    o_m_tdata,
    input logic                           o_m_tlast
);
    import hcfe_pkg::*;

    // stalled output beat holds its payload
    `HCFE_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "output beat changed while stalled")

    // reset empties the output register
    `HCFE_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

    // reset empties the queue, so the input side is ready right away
    `HCFE_ASSERT_ALWAYS(a_rst_ready, i_clk, !i_rst_n |=> o_s_tready, "input not ready after reset")

    // nothing queued and nothing pending: no output beat can appear
    `HCFE_ASSERT_RST(a_no_phantom, i_clk, i_rst_n, !i_rst_n ##1 !(i_s_tvalid && o_s_tready) |=> !o_m_tvalid, "output beat without input")

endmodule

bind hex_checksum_frame_encoder hcfe_checker u_checker (.*);

// ----- bench/testbench.sv -----
// Self-checking bench for the STX/ETX frame encoder: directed table, random frames, back-pressure.
`timescale 1ns / 1ps

module testbench;
    import hcfe_pkg::*;

    localparam int RESET_CYCLES     = 7;
    localparam int RANDOM_BEATS     = 455;
    localparam int NUM_PHASES       = 6;
    localparam int LONG_HOLD_CYCLES = 240;   // receiver hold-off, well past queue depth
    localparam int STALL_LIMIT      = 2000;  // cycles without any beat before giving up
    localparam int SETTLE_CYCLES    = 4;     // > pipeline latency through queue and output register
    localparam int DRAIN_CYCLES     = 10;
    localparam int TAIL_LEN         = 7;     // outputs of a single-byte frame

    // Indexes that map to no register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE_LO = CFG_IDX_END + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE_HI = '1;

    localparam logic [127:0] HEX_CHARS = "0123456789ABCDEF";

    typedef enum logic [1:0] {
        ROW_BEAT,   // payload beat, checked against the predictor
        ROW_TYPED,  // single-byte frame, expected tail typed in the row
        ROW_CFG     // register write, block drained first
    } t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        logic [CFG_IDX_W-1:0]     idx;
        logic [BYTE_W-1:0]        data;
        logic                     last;
        logic [8*TAIL_LEN-1:0]    tail;  // first output byte in the top bits
    } t_dir_row;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              fin;
    } t_framed_byte;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [BYTE_W-1:0]    i_s_tdata   = '0;    // [7:0] payload_byte
    logic                 i_s_tlast   = 1'b0;  // last_in_frame
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [BYTE_W-1:0]    o_m_tdata;           // [7:0] out_byte
    logic                 o_m_tlast;           // run_last
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BYTE_W-1:0]    i_cfg_data  = '0;

    hex_checksum_frame_encoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Encoder predictor: own copy of registers and frame state
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] cur_start  = START_RESET;
    logic [BYTE_W-1:0] cur_end    = END_RESET;
    logic [BYTE_W-1:0] run_sum    = '0;
    logic [BYTE_W-1:0] run_xor    = '0;
    logic              frame_open = 1'b0;
    t_framed_byte      beat_bytes [TAIL_LEN];

    t_framed_byte framed_q [$];  // bytes still owed by the encoder, oldest first

    bit idle_on    = 1'b1;  // random gaps on both sides
    bit long_hold  = 1'b0;  // request for one long receiver hold-off
    int mismatches = 0;

    function automatic logic [BYTE_W-1:0] to_hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return "0" + {4'h0, nib};
        end
        return "A" + {4'h0, nib} - 8'd10;
    endfunction

    // Fills beat_bytes with the framed bytes for one payload beat; returns the count.
    function automatic int encode_beat(input logic [BYTE_W-1:0] d, input logic l);
        int n;
        n = 0;
        if (!frame_open) begin
            beat_bytes[n] = '{cur_start, 1'b0};
            n = n + 1;
            frame_open = 1'b1;
        end
        run_sum = run_sum + d;
        run_xor = run_xor ^ d;
        if (!l) begin
            // mid-frame byte is the whole answer to its beat
            beat_bytes[n] = '{d, 1'b1};
            return n + 1;
        end
        beat_bytes[n]     = '{d, 1'b0};
        beat_bytes[n + 1] = '{to_hex_char(run_sum[7:4]), 1'b0};
        beat_bytes[n + 2] = '{to_hex_char(run_sum[3:0]), 1'b0};
        beat_bytes[n + 3] = '{to_hex_char(run_xor[7:4]), 1'b0};
        beat_bytes[n + 4] = '{to_hex_char(run_xor[3:0]), 1'b0};
        beat_bytes[n + 5] = '{cur_end, 1'b1};
        run_sum    = '0;
        run_xor    = '0;
        frame_open = 1'b0;
        return n + 6;
    endfunction

    function automatic t_dir_row mk_row(input t_row_kind kind,
                                        input logic [CFG_IDX_W-1:0] idx,
                                        input logic [BYTE_W-1:0] data,
                                        input logic last,
                                        input logic [8*TAIL_LEN-1:0] tail);
        t_dir_row r;
        r.kind = kind;
        r.idx  = idx;
        r.data = data;
        r.last = last;
        r.tail = tail;
        return r;
    endfunction

    // Mostly ASCII hex characters, as in real frames, the rest any byte.
    function automatic logic [BYTE_W-1:0] pick_byte();
        int n;
        if ($urandom_range(0, 3) != 0) begin
            n = $urandom_range(0, 15);
            return HEX_CHARS[8*(15-n) +: 8];
        end
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic void note_mismatch(input string what, input logic [BYTE_W-1:0] want,
                                          input logic [BYTE_W-1:0] got);
        mismatches++;
        $display("%0t: %s mismatch: expected %02h, actual %02h", $time, what, want, got);
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    task automatic sender_gap();
        if (idle_on && !long_hold && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // Offers one payload beat, holds it until accepted, then books the expected bytes.
    task automatic send_beat(input logic [BYTE_W-1:0] d, input logic l, input logic typed,
                             input logic [8*TAIL_LEN-1:0] tail);
        int n;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tlast  <= l;
        do @(posedge i_clk); while (!o_s_tready);
        n = encode_beat(d, l);
        if (typed) begin
            // typed rows are single-byte frames: the full seven-byte frame
            for (int k = 0; k < TAIL_LEN; k++) begin
                framed_q.push_back(t_framed_byte'{tail[8*(TAIL_LEN-1-k) +: 8],
                                                  k == TAIL_LEN - 1});
            end
        end else begin
            for (int k = 0; k < n; k++) begin
                framed_q.push_back(beat_bytes[k]);
            end
        end
    endtask

    // Stop offering and wait for every owed byte, plus the pipeline latency.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (framed_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_IDX_START) begin
            cur_start = val;
        end else if (idx == CFG_IDX_END) begin
            cur_end = val;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random tready bursts, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : receiver
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output check: every accepted beat against the oldest owed byte
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_framed_byte want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (framed_q.size() == 0) begin
                note_mismatch("unexpected beat, out_byte", 8'h00, o_m_tdata);
            end else begin
                want = framed_q.pop_front();
                if (o_m_tdata !== want.data) begin
                    note_mismatch("out_byte", want.data, o_m_tdata);
                end
                if (o_m_tlast !== want.fin) begin
                    note_mismatch("run_last", {7'h0, want.fin}, {7'h0, o_m_tlast});
                end
            end
        end
    end

    // Watchdog: too long without a beat on any channel means a hang.
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("testbench: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_dir_row          rows [$];
        logic [BYTE_W-1:0] s_val;
        logic [BYTE_W-1:0] e_val;
        int                len;
        int                sent;
        int                frames;

        // Directed part. Typed tails: start, byte, sum hi/lo, xor hi/lo, end.
        // single-byte frames at both byte extremes, reset registers
        rows.push_back(mk_row(ROW_TYPED, '0, 8'h00, 1'b1, 56'h02_00_30_30_30_30_03));
        rows.push_back(mk_row(ROW_TYPED, '0, 8'hFF, 1'b1, 56'h02_FF_46_46_46_46_03));
        // longer frame with a zero byte in the middle, which must not close it
        rows.push_back(mk_row(ROW_BEAT, '0, "A",   1'b0, '0));
        rows.push_back(mk_row(ROW_BEAT, '0, "0",   1'b0, '0));
        rows.push_back(mk_row(ROW_BEAT, '0, 8'h00, 1'b0, '0));
        rows.push_back(mk_row(ROW_BEAT, '0, "F",   1'b0, '0));
        rows.push_back(mk_row(ROW_BEAT, '0, 8'h7F, 1'b0, '0));
        rows.push_back(mk_row(ROW_BEAT, '0, 8'h80, 1'b0, '0));
        rows.push_back(mk_row(ROW_BEAT, '0, "Z",   1'b1, '0));
        // register extremes, and a write to an unmapped index
        rows.push_back(mk_row(ROW_CFG, CFG_IDX_START,   8'h00, 1'b0, '0));
        rows.push_back(mk_row(ROW_CFG, CFG_IDX_END,     8'hFF, 1'b0, '0));
        rows.push_back(mk_row(ROW_CFG, CFG_IDX_NONE_LO, 8'h55, 1'b0, '0));
        rows.push_back(mk_row(ROW_TYPED, '0, 8'h00, 1'b1, 56'h00_00_30_30_30_30_FF));
        rows.push_back(mk_row(ROW_CFG, CFG_IDX_START,   8'hFF, 1'b0, '0));
        rows.push_back(mk_row(ROW_CFG, CFG_IDX_END,     8'h00, 1'b0, '0));
        rows.push_back(mk_row(ROW_CFG, CFG_IDX_NONE_HI, 8'hAA, 1'b0, '0));
        // end byte rewritten while a frame is open; the tail uses the new value
        rows.push_back(mk_row(ROW_BEAT, '0, 8'h01, 1'b0, '0));
        rows.push_back(mk_row(ROW_BEAT, '0, 8'h55, 1'b0, '0));
        rows.push_back(mk_row(ROW_CFG, CFG_IDX_END, "Z", 1'b0, '0));
        rows.push_back(mk_row(ROW_BEAT, '0, 8'hAA, 1'b0, '0));
        rows.push_back(mk_row(ROW_BEAT, '0, 8'hFE, 1'b1, '0));
        rows.push_back(mk_row(ROW_TYPED, '0, 8'h80, 1'b1, 56'hFF_80_38_30_38_30_5A));
        rows.push_back(mk_row(ROW_BEAT, '0, "C",   1'b1, '0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_CFG) begin
                write_reg(rows[r].idx, rows[r].data);
            end else begin
                sender_gap();
                send_beat(rows[r].data, rows[r].last, rows[r].kind == ROW_TYPED, rows[r].tail);
            end
        end

        // Random frames in phases, each with its own start/end setting.
        // Phase 2 runs without gaps; the last phase runs flat out.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            idle_on = (ph != 2) && (ph != NUM_PHASES - 1);
            case (ph)
                0: begin
                    s_val = 8'h00;
                    e_val = 8'h00;
                end
                1: begin
                    s_val = 8'hFF;
                    e_val = 8'hFF;
                end
                default: begin
                    s_val = BYTE_W'($urandom_range(0, 255));
                    e_val = BYTE_W'($urandom_range(0, 255));
                end
            endcase
            write_reg(CFG_IDX_START, s_val);
            write_reg(CFG_IDX_END, e_val);
            if (ph == 1 || ph == 4) begin
                write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_NONE_LO, CFG_IDX_NONE_HI)),
                          BYTE_W'($urandom_range(0, 255)));
            end

            sent   = 0;
            frames = 0;
            while (sent < RANDOM_BEATS / NUM_PHASES) begin
                // phase 3: receiver stalls long while we keep pushing, so the
                // internal queue fills and the input side must back off
                if (ph == 3 && frames == 0) begin
                    long_hold = 1'b1;
                end
                // phase 4: sender goes quiet once until the encoder has flushed
                if (ph == 4 && frames == 2) begin
                    wait_drained();
                end
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
                for (int k = 0; k < len; k++) begin
                    sender_gap();
                    send_beat(pick_byte(), k == len - 1, 1'b0, '0);
                    sent++;
                end
                frames++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/hcfe_pkg.sv
rtl/core/hcfe_fifo.sv
rtl/core/hcfe_front.sv
rtl/core/hcfe_back.sv
rtl/core/hex_checksum_frame_encoder.sv
rtl/core/hcfe_checker.sv
bench/testbench.sv
